// ===== rtl/fspa_pkg.sv =====
package fspa_pkg;

   localparam int MAX_SLOTS  = 256;
   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int OFF_W      = 20;
   localparam int SB_W       = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int RSP_W      = 1 + SLOT_W + OFF_W + 2 + CNT_W;

   localparam logic [CNT_W-1:0] USED_MAX = {CNT_W{1'b1}};

   // input command kinds
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // release status codes
   localparam logic [1:0] REL_NONE      = 2'd0;
   localparam logic [1:0] REL_ORDINARY  = 2'd1;
   localparam logic [1:0] REL_EMPTY     = 2'd2;
   localparam logic [1:0] REL_LEFT_FULL = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_BYTES,
      CSR_SLOT_BYTES,
      CSR_SLOT_COUNT
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic load_rsp;
   } dp_cmd_type;

endpackage

// ===== rtl/fspa_ram.sv =====
module fspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fspa_ctrl.sv =====
module fspa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output fspa_pkg::dp_cmd_type cmd
);

   fspa_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fspa_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = fspa_pkg::ST_EXEC;
         end
         fspa_pkg::ST_EXEC: begin
            state_in = fspa_pkg::ST_FIN;
         end
         fspa_pkg::ST_FIN: begin
            if (rsp_free) state_in = fspa_pkg::ST_IDLE;
         end
         default: begin
            state_in = fspa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd.load_req = 1'b0;
      cmd.exec     = 1'b0;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         fspa_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         fspa_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         fspa_pkg::ST_FIN: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // result register stays full until the receiver takes the beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fspa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !cmd.load_rsp)
      else $error("waiting result overwritten");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is at work");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_req, cmd.exec, cmd.load_rsp}))
      else $error("datapath commands overlap");

endmodule

// ===== rtl/fspa_dp.sv =====
module fspa_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  fspa_pkg::dp_cmd_type             cmd,
   input  logic                            req_cmd,
   input  logic [fspa_pkg::SLOT_W-1:0]     req_slot,
   input  logic                            csr_wr_en,
   input  logic [fspa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fspa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [fspa_pkg::RSP_W-1:0]      rsp_data
);

   // configuration
   logic [fspa_pkg::OFF_W-1:0] block_bytes_ff;
   logic [fspa_pkg::SB_W-1:0]  slot_bytes_ff;
   logic [fspa_pkg::CNT_W-1:0] slot_count_ff;

   // allocator state
   logic [fspa_pkg::CNT_W-1:0] free_head_ff, free_head_in;
   logic [fspa_pkg::CNT_W-1:0] fresh_next_ff, fresh_next_in;
   logic [fspa_pkg::CNT_W-1:0] used_ff, used_in;

   // latched request and per-item results
   logic                        cmd_ff;
   logic [fspa_pkg::SLOT_W-1:0] slot_ff;
   logic                        granted_ff, granted_in;
   logic [fspa_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [1:0]                  status_ff, status_in;
   logic [fspa_pkg::OFF_W-1:0]  prod_ff;
   logic [fspa_pkg::RSP_W-1:0]  rsp_data_ff;

   logic [fspa_pkg::CNT_W-1:0]  pool;
   logic [fspa_pkg::CNT_W-1:0]  used_dec;
   logic [fspa_pkg::CNT_W-1:0]  link_rd;
   logic                        link_wr;
   logic signed [fspa_pkg::CNT_W:0]   diff;
   logic signed [fspa_pkg::SB_W:0]    sb_s;
   logic signed [fspa_pkg::CNT_W+fspa_pkg::SB_W+1:0] prod_full;
   logic [fspa_pkg::OFF_W-1:0]  offset;

   fspa_ram #(
      .WIDTH (fspa_pkg::CNT_W),
      .DEPTH (fspa_pkg::MAX_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr),
      .wr_addr (slot_ff),
      .wr_data (free_head_ff),
      .rd_addr (free_head_ff[fspa_pkg::SLOT_W-1:0]),
      .rd_data (link_rd)
   );

   assign pool = (slot_count_ff > fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS))
               ? fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS) : slot_count_ff;
   assign used_dec = used_ff - fspa_pkg::CNT_W'(1);

   always_comb begin
      free_head_in  = free_head_ff;
      fresh_next_in = fresh_next_ff;
      used_in       = used_ff;
      granted_in    = 1'b0;
      idx_in        = '0;
      status_in     = fspa_pkg::REL_NONE;
      link_wr       = 1'b0;
      if (cmd_ff == fspa_pkg::CMD_ALLOC) begin
         if (free_head_ff < fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS)) begin
            idx_in       = free_head_ff[fspa_pkg::SLOT_W-1:0];
            free_head_in = link_rd;
            granted_in   = 1'b1;
         end else if (fresh_next_ff < pool) begin
            idx_in        = fresh_next_ff[fspa_pkg::SLOT_W-1:0];
            fresh_next_in = fresh_next_ff + fspa_pkg::CNT_W'(1);
            granted_in    = 1'b1;
         end
         if (granted_in && used_ff != fspa_pkg::USED_MAX) begin
            used_in = used_ff + fspa_pkg::CNT_W'(1);
         end
      end else begin
         idx_in = slot_ff;
         if ({1'b0, slot_ff} < pool && used_ff != '0) begin
            link_wr      = cmd.exec;
            free_head_in = {1'b0, slot_ff};
            used_in      = used_dec;
            granted_in   = 1'b1;
            if (used_dec == '0) status_in = fspa_pkg::REL_EMPTY;
            else if (used_ff == pool) status_in = fspa_pkg::REL_LEFT_FULL;
            else status_in = fspa_pkg::REL_ORDINARY;
         end
      end
   end

   // offset = block_bytes + (idx - pool) * slot_bytes, modulo 2^20
   assign diff      = $signed({2'b00, idx_in}) - $signed({1'b0, pool});
   assign sb_s      = $signed({1'b0, slot_bytes_ff});
   assign prod_full = diff * sb_s;
   assign offset    = granted_ff ? (block_bytes_ff + prod_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= '0;
         slot_bytes_ff  <= fspa_pkg::SB_W'(8);
         slot_count_ff  <= '0;
         free_head_ff   <= fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS);
         fresh_next_ff  <= '0;
         used_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               fspa_pkg::CSR_BLOCK_BYTES: block_bytes_ff <= csr_wdata;
               fspa_pkg::CSR_SLOT_BYTES:  slot_bytes_ff  <= csr_wdata[fspa_pkg::SB_W-1:0];
               fspa_pkg::CSR_SLOT_COUNT:  slot_count_ff  <= csr_wdata[fspa_pkg::CNT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.exec) begin
            free_head_ff  <= free_head_in;
            fresh_next_ff <= fresh_next_in;
            used_ff       <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff  <= req_cmd;
         slot_ff <= req_slot;
      end
      if (cmd.exec) begin
         granted_ff <= granted_in;
         idx_ff     <= idx_in;
         status_ff  <= status_in;
         prod_ff    <= prod_full[fspa_pkg::OFF_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= {used_ff, status_ff, offset, idx_ff, granted_ff};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== rtl/fixed_slot_pool_allocator_top.sv =====
// Fixed-slot pool allocator.
// Request channel (req_): tuser carries the command (0 allocate, 1 release),
// tdata the slot to release. Every request beat yields exactly one response
// beat on rsp_ with grant flag, slot index, byte offset, release status and
// the in-use count after the request.
// A request accepted in ST_IDLE passes through ST_EXEC (allocator update,
// offset product registered) and ST_FIN, which loads the response register
// behind rsp_tvalid. One request at a time: req_tready is high only in ST_IDLE.
// The result sits in an output register, so the next request is accepted
// while a response still waits; when the receiver stalls the block finishes
// that request and holds it until the response register frees up.
// Reset (synchronous, active high) empties the free list, rewinds the fresh
// slot pointer, clears the in-use count and loads the register defaults.
// The link memory needs no clearing pass; entries are read only after a
// release wrote them. csr_ writes belong in idle periods, with no request
// in flight.
module fixed_slot_pool_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fspa_pkg::SLOT_W-1:0]     req_tdata,  // slot
   input  logic                            req_tuser,  // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // granted, slot_index, byte_offset, release_status, in_use
   output logic [fspa_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [fspa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fspa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   fspa_pkg::dp_cmd_type dp_cmd;

   fspa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (dp_cmd)
   );

   fspa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .req_cmd   (req_tuser),
      .req_slot  (req_tdata),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

endmodule

// ===== bench/tb_fixed_slot_pool_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_fixed_slot_pool_allocator_top;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 6;
   localparam int MIXED_ITEMS  = 320;

   // rsp_tdata layout, highest bit first
   typedef struct packed {
      logic [fspa_pkg::CNT_W-1:0]  in_use;
      logic [1:0]                  release_status;
      logic [fspa_pkg::OFF_W-1:0]  byte_offset;
      logic [fspa_pkg::SLOT_W-1:0] slot_index;
      logic                        granted;
   } pool_result_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [fspa_pkg::SLOT_W-1:0]     req_tdata  = '0;
   logic                            req_tuser  = fspa_pkg::CMD_ALLOC;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [fspa_pkg::RSP_W-1:0]      rsp_tdata;
   logic                            csr_wr_en  = 1'b0;
   logic [fspa_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [fspa_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // predicted allocator state and registers
   logic [fspa_pkg::CNT_W-1:0] link_mem [fspa_pkg::MAX_SLOTS];
   logic [fspa_pkg::CNT_W-1:0] head_slot       = fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS);
   logic [fspa_pkg::CNT_W-1:0] fresh_slot      = '0;
   logic [fspa_pkg::CNT_W-1:0] used_slots      = '0;
   logic [fspa_pkg::OFF_W-1:0] cfg_block_bytes = '0;
   logic [fspa_pkg::SB_W-1:0]  cfg_slot_bytes  = fspa_pkg::SB_W'(8);
   logic [fspa_pkg::CNT_W-1:0] cfg_slot_count  = '0;

   pool_result_type pending_results[$];
   pool_result_type seen_result;
   pool_result_type due_result;
   int              live_slots[$];
   int              last_released = 0;
   int              mismatches    = 0;
   int              quiet_cycles  = 0;
   int              sink_hold     = 0;
   int              sink_roll;
   bit              calm          = 1'b0;

   fixed_slot_pool_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [fspa_pkg::CNT_W-1:0] pool_size();
      return (cfg_slot_count < fspa_pkg::MAX_SLOTS)
           ? cfg_slot_count : fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS);
   endfunction

   function automatic logic [fspa_pkg::OFF_W-1:0] slot_offset(
      input logic [fspa_pkg::SLOT_W-1:0] idx);
      logic [39:0] span;
      // wide enough that the low bits come out right even when the base goes negative
      span = 40'(cfg_block_bytes) - 40'(pool_size()) * 40'(cfg_slot_bytes)
           + 40'(idx) * 40'(cfg_slot_bytes);
      return span[fspa_pkg::OFF_W-1:0];
   endfunction

   function automatic pool_result_type apply_pool_request(
      input logic cmd, input logic [fspa_pkg::SLOT_W-1:0] slot);
      pool_result_type            res;
      logic [fspa_pkg::CNT_W-1:0] pool;
      logic                       ok;
      pool = pool_size();
      res  = '0;
      ok   = 1'b0;
      if (cmd == fspa_pkg::CMD_ALLOC) begin
         if (head_slot < fspa_pkg::MAX_SLOTS) begin
            res.slot_index = head_slot[fspa_pkg::SLOT_W-1:0];
            head_slot      = link_mem[head_slot[fspa_pkg::SLOT_W-1:0]];
            ok             = 1'b1;
         end else if (fresh_slot < pool) begin
            res.slot_index = fresh_slot[fspa_pkg::SLOT_W-1:0];
            fresh_slot     = fresh_slot + 1'b1;
            ok             = 1'b1;
         end
         if (ok) begin
            res.granted     = 1'b1;
            res.byte_offset = slot_offset(res.slot_index);
            if (used_slots != fspa_pkg::USED_MAX) used_slots = used_slots + 1'b1;
         end
      end else begin
         res.slot_index = slot;
         if (slot < pool && used_slots != 0) begin
            link_mem[slot]  = head_slot;
            head_slot       = fspa_pkg::CNT_W'(slot);
            used_slots      = used_slots - 1'b1;
            res.granted     = 1'b1;
            res.byte_offset = slot_offset(slot);
            // empty wins over left-full when both hold
            if (used_slots == 0) res.release_status = fspa_pkg::REL_EMPTY;
            else if (used_slots + 1 == pool) res.release_status = fspa_pkg::REL_LEFT_FULL;
            else res.release_status = fspa_pkg::REL_ORDINARY;
         end
      end
      res.in_use = used_slots;
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [fspa_pkg::SLOT_W-1:0] pick_release_slot();
      int roll;
      int pool;
      roll = $urandom_range(0, 99);
      pool = pool_size();
      if (roll < 65 && live_slots.size() != 0)
         return fspa_pkg::SLOT_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
      if (roll < 75) return fspa_pkg::SLOT_W'(last_released);
      if (roll < 88) return fspa_pkg::SLOT_W'($urandom_range(0, 255));
      // just inside or just outside the pool
      if (pool > 255) return fspa_pkg::SLOT_W'(255);
      if (pool == 0) return '0;
      return roll[0] ? fspa_pkg::SLOT_W'(pool) : fspa_pkg::SLOT_W'(pool - 1);
   endfunction

   task automatic send_request(input logic cmd, input logic [fspa_pkg::SLOT_W-1:0] slot);
      int              gap;
      int              hits[$];
      pool_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= slot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = apply_pool_request(cmd, slot);
      pending_results.push_back(res);
      if (res.granted) begin
         if (cmd == fspa_pkg::CMD_ALLOC) begin
            live_slots.push_back(int'(res.slot_index));
         end else begin
            last_released = int'(slot);
            hits = live_slots.find_first_index(x) with (x == int'(slot));
            if (hits.size() != 0) live_slots.delete(hits[0]);
         end
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_pool(input logic [fspa_pkg::OFF_W-1:0] block_bytes,
                           input logic [fspa_pkg::SB_W-1:0] slot_bytes,
                           input logic [fspa_pkg::CNT_W-1:0] slot_count);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= fspa_pkg::CSR_BLOCK_BYTES;
      csr_wdata <= block_bytes;
      @(posedge clock);
      csr_index <= fspa_pkg::CSR_SLOT_BYTES;
      csr_wdata <= fspa_pkg::CSR_DATA_W'(slot_bytes);
      @(posedge clock);
      csr_index <= fspa_pkg::CSR_SLOT_COUNT;
      csr_wdata <= fspa_pkg::CSR_DATA_W'(slot_count);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_block_bytes = block_bytes;
      cfg_slot_bytes  = slot_bytes;
      cfg_slot_count  = slot_count;
   endtask

   task automatic run_traffic_phase(input int items, input int alloc_pct);
      repeat (items) begin
         if ($urandom_range(0, 99) < alloc_pct)
            send_request(fspa_pkg::CMD_ALLOC, fspa_pkg::SLOT_W'($urandom_range(0, 255)));
         else
            send_request(fspa_pkg::CMD_RELEASE, pick_release_slot());
      end
   endtask

   // register defaults give an empty pool: nothing can be granted
   task automatic test_idle_pool();
      send_request(fspa_pkg::CMD_ALLOC, '0);
      send_request(fspa_pkg::CMD_RELEASE, '0);
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(255));
   endtask

   task automatic test_fill_and_drain();
      set_pool(20'd1000, 16'd24, 9'd4);
      repeat (5) send_request(fspa_pkg::CMD_ALLOC, '0);
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(4));
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(3));
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(255));
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(0));
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(1));
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(2));
   endtask

   // same slot released twice is handed out twice
   task automatic test_double_release();
      repeat (3) send_request(fspa_pkg::CMD_ALLOC, '0);
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(1));
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(1));
      repeat (2) send_request(fspa_pkg::CMD_ALLOC, '1);
   endtask

   // pool shrinks under slots in use, largest sizes
   task automatic test_register_extremes();
      set_pool('1, '1, 9'd1);
      send_request(fspa_pkg::CMD_ALLOC, '0);
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(0));
      send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(1));
      send_request(fspa_pkg::CMD_ALLOC, '0);
   endtask

   task automatic test_random_traffic();
      int                         sent;
      int                         phase;
      int                         roll;
      logic [fspa_pkg::OFF_W-1:0] blk;
      logic [fspa_pkg::SB_W-1:0]  sb;
      logic [fspa_pkg::CNT_W-1:0] cnt;
      int                         items;
      sent  = 0;
      phase = 0;
      while (sent < MIXED_ITEMS) begin
         case (phase)
            0: begin
               blk = '1; sb = '1; cnt = 9'd511;
            end
            1: begin
               blk = '0; sb = 16'd1; cnt = 9'd257;
            end
            2: begin
               blk = 20'd12345; sb = 16'd7; cnt = '0;
            end
            default: begin
               blk  = fspa_pkg::OFF_W'($urandom_range(0, 20'hFFFFF));
               sb   = ($urandom_range(0, 3) == 0)
                    ? fspa_pkg::SB_W'($urandom_range(1, 16'hFFFF))
                    : fspa_pkg::SB_W'($urandom_range(1, 64));
               roll = $urandom_range(0, 99);
               if (roll < 65) cnt = fspa_pkg::CNT_W'($urandom_range(1, 12));
               else if (roll < 80) cnt = fspa_pkg::CNT_W'($urandom_range(13, 64));
               else if (roll < 90) cnt = '0;
               else cnt = fspa_pkg::CNT_W'($urandom_range(200, 511));
            end
         endcase
         calm = ($urandom_range(0, 4) == 0);
         set_pool(blk, sb, cnt);
         items = $urandom_range(30, 70);
         run_traffic_phase(items, $urandom_range(30, 75));
         sent  += items;
         phase++;
      end
   endtask

   // fill the largest pool to the top, then hand everything back
   task automatic test_large_pool();
      calm = 1'b0;
      set_pool('0, '1, 9'd256);
      run_traffic_phase(280, 97);
      calm = 1'b1;
      while (live_slots.size() != 0 && used_slots != 0)
         send_request(fspa_pkg::CMD_RELEASE, fspa_pkg::SLOT_W'(live_slots[0]));
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         sink_roll = $urandom_range(0, 99);
         if (sink_roll < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            sink_hold  <= (sink_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_result = rsp_tdata;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp beat with nothing pending: %h", rsp_tdata);
         end else begin
            due_result = pending_results.pop_front();
            if (seen_result.granted !== due_result.granted
                || seen_result.slot_index !== due_result.slot_index
                || seen_result.byte_offset !== due_result.byte_offset
                || seen_result.release_status !== due_result.release_status
                || seen_result.in_use !== due_result.in_use) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"rsp mismatch: expected granted %0d slot %0d offset %0d ",
                            "status %0d in_use %0d, got %0d %0d %0d %0d %0d"},
                           due_result.granted, due_result.slot_index,
                           due_result.byte_offset, due_result.release_status,
                           due_result.in_use, seen_result.granted,
                           seen_result.slot_index, seen_result.byte_offset,
                           seen_result.release_status, seen_result.in_use);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_idle_pool();
      test_fill_and_drain();
      test_double_release();
      test_register_extremes();
      test_random_traffic();
      test_large_pool();
      wait_idle();
      if (mismatches == 0 && pending_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
